// ===== design/pcb32_pkg.sv =====
`default_nettype none

package pcb32_pkg;

	// result kind carried on tuser
	typedef enum logic {
		KIND_DATA   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	// final status codes
	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_BAD_CHAR     = 2'd1,
		ST_BAD_CHECKSUM = 2'd2,
		ST_TOO_SHORT    = 2'd3
	} status_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_value;
		status_t    status;
		logic       end_of_run;
	} res_t;

	typedef struct packed {
		logic       valid;
		logic [4:0] sym;
	} sym_t;

	localparam int unsigned DELAY_DEPTH   = 8;
	localparam int unsigned RES_DEPTH     = 4;
	localparam logic [7:0]  MIN_BYTES_RST = 8'd72;
	localparam logic [7:0]  CNT_MAX       = 8'd255;
	localparam logic [39:0] CHK_GOOD      = 40'd1;

	localparam logic [39:0] GEN [5] = '{
		40'h98f2bc8e61, 40'h79b76d99e2, 40'hf33e5fb3c4,
		40'hae2eabe2a8, 40'h1e4f43e470
	};

	// "paycode", each letter masked to five bits
	localparam logic [4:0] PREFIX_SYM [7] = '{
		5'h10, 5'h01, 5'h19, 5'h03, 5'h0f, 5'h04, 5'h05
	};

	// one polymod step
	function automatic logic [39:0] poly_fold(logic [39:0] c, logic [4:0] d);
		logic [4:0]  top;
		logic [39:0] r;
		top = c[39:35];
		r   = {c[34:0], 5'b0} ^ {35'b0, d};
		for (int i = 0; i < 5; i++) begin
			if (top[i]) r = r ^ GEN[i];
		end
		return r;
	endfunction

	function automatic logic [39:0] chk_start();
		logic [39:0] c;
		c = 40'd1;
		for (int i = 0; i < 7; i++) begin
			c = poly_fold(c, PREFIX_SYM[i]);
		end
		return poly_fold(c, 5'd0);
	endfunction

	localparam logic [39:0] CHK_INIT = chk_start();

	// case-insensitive charset lookup
	function automatic sym_t map_char(logic [7:0] ch);
		logic [7:0] lc;
		sym_t       s;
		lc = ch;
		if (ch >= "A" && ch <= "Z") lc = ch | 8'h20;
		s.valid = 1'b1;
		case (lc)
			"q": s.sym = 5'd0;
			"p": s.sym = 5'd1;
			"z": s.sym = 5'd2;
			"r": s.sym = 5'd3;
			"y": s.sym = 5'd4;
			"9": s.sym = 5'd5;
			"x": s.sym = 5'd6;
			"8": s.sym = 5'd7;
			"g": s.sym = 5'd8;
			"f": s.sym = 5'd9;
			"2": s.sym = 5'd10;
			"t": s.sym = 5'd11;
			"v": s.sym = 5'd12;
			"d": s.sym = 5'd13;
			"w": s.sym = 5'd14;
			"0": s.sym = 5'd15;
			"s": s.sym = 5'd16;
			"3": s.sym = 5'd17;
			"j": s.sym = 5'd18;
			"n": s.sym = 5'd19;
			"5": s.sym = 5'd20;
			"4": s.sym = 5'd21;
			"k": s.sym = 5'd22;
			"h": s.sym = 5'd23;
			"c": s.sym = 5'd24;
			"e": s.sym = 5'd25;
			"6": s.sym = 5'd26;
			"m": s.sym = 5'd27;
			"u": s.sym = 5'd28;
			"a": s.sym = 5'd29;
			"7": s.sym = 5'd30;
			"l": s.sym = 5'd31;
			default: begin
				s.valid = 1'b0;
				s.sym   = 5'd0;
			end
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== design/paycode_base32_checksum_decoder.sv =====
`default_nettype none

// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tdata[7:0] char_code, tlast last
// m_axis    out  tvalid/tready           tdata[7:0] byte_value, tdata[9:8] status,
//                                        tuser kind, tlast end_of_run
// cfg       in   cfg_we (no back-press.) cfg_wdata min_bytes
//
// One character per cycle sustained while the result queue holds two results
// or fewer. A request is registered (s1), then folded into the polymod, shifted
// through the delay line and regrouped combinationally, writing up to two results
// into a four-entry result queue that drives m_axis.
// The s1 stage advances while the queue holds two results or fewer, so a
// stalled output stops the input after the queue fills; no comb path runs
// from m_axis_tready to s_axis_tready.
// arst_n clears control state, counters and the polymod (to the prefix value);
// min_bytes resets to 72.

module paycode_base32_checksum_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  wire logic        s_axis_tlast,   // last
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [7:0] byte_value, [9:8] status
	output logic             m_axis_tuser,   // kind
	output logic             m_axis_tlast,   // end_of_run
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata       // min_bytes
);

	localparam int unsigned PTR_W = $clog2(pcb32_pkg::RES_DEPTH);
	localparam int unsigned CNT_W = $clog2(pcb32_pkg::RES_DEPTH + 1);

	// config
	logic [7:0] min_bytes_q;

	// input stage
	logic       v_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// run state
	logic [39:0] chk_q;
	logic [4:0]  delay_q [pcb32_pkg::DELAY_DEPTH];
	logic [7:0]  sym_cnt_q;
	logic [11:0] acc_q;
	logic [2:0]  bcnt_q;
	logic [7:0]  byte_cnt_q;
	logic        bad_q;

	// result queue
	pcb32_pkg::res_t res_q [pcb32_pkg::RES_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic in_acc, proc, pop;

	// datapath
	pcb32_pkg::sym_t    ms;
	logic [39:0]        chk_n;
	logic [7:0]         sym_cnt_n;
	logic [11:0]        acc_n;
	logic [2:0]         bcnt_n;
	logic [7:0]         byte_cnt_n;
	logic               bad_n;
	logic               push_byte;
	logic [7:0]         byte_n;
	pcb32_pkg::status_t st_n;
	logic [3:0]         bits;
	logic [11:0]        acc_sh;
	logic [1:0]         n_push;

	assign s_axis_tready = !v_s1 || (cnt_q <= CNT_W'(2));
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign proc          = v_s1 && (cnt_q <= CNT_W'(2));
	assign pop           = m_axis_tvalid && m_axis_tready;

	always_comb begin
		ms         = pcb32_pkg::map_char(char_s1);
		chk_n      = chk_q;
		sym_cnt_n  = sym_cnt_q;
		acc_n      = acc_q;
		bcnt_n     = bcnt_q;
		byte_cnt_n = byte_cnt_q;
		bad_n      = bad_q;
		push_byte  = 1'b0;
		bits       = {1'b0, bcnt_q} + 4'd5;
		acc_sh     = 12'd0;
		if (!ms.valid) begin
			bad_n = 1'b1;
		end else begin
			chk_n = pcb32_pkg::poly_fold(chk_q, ms.sym);
			if (sym_cnt_q != pcb32_pkg::CNT_MAX) sym_cnt_n = sym_cnt_q + 8'd1;
			// oldest symbol leaves the delay line once it is full
			if (sym_cnt_q >= 8'(pcb32_pkg::DELAY_DEPTH)) begin
				acc_n = {acc_q[6:0], delay_q[pcb32_pkg::DELAY_DEPTH-1]};
				if (bits >= 4'd8) begin
					push_byte = 1'b1;
					bits      = bits - 4'd8;
					acc_sh    = acc_n >> bits;
					if (byte_cnt_q != pcb32_pkg::CNT_MAX) byte_cnt_n = byte_cnt_q + 8'd1;
				end
				bcnt_n = bits[2:0];
			end
		end
		byte_n = acc_sh[7:0];
		// status priority: bad char, too few symbols, checksum, too few bytes
		if (bad_n)                                           st_n = pcb32_pkg::ST_BAD_CHAR;
		else if (sym_cnt_n < 8'(pcb32_pkg::DELAY_DEPTH))     st_n = pcb32_pkg::ST_TOO_SHORT;
		else if (chk_n != pcb32_pkg::CHK_GOOD)               st_n = pcb32_pkg::ST_BAD_CHECKSUM;
		else if (byte_cnt_n < min_bytes_q)                   st_n = pcb32_pkg::ST_TOO_SHORT;
		else                                                 st_n = pcb32_pkg::ST_OK;
		n_push = proc ? ({1'b0, push_byte} + {1'b0, last_s1}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_bytes_q <= pcb32_pkg::MIN_BYTES_RST;
		end else if (cfg_we) begin
			min_bytes_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (proc) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// run state; cleared after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q      <= pcb32_pkg::CHK_INIT;
			sym_cnt_q  <= 8'd0;
			acc_q      <= 12'd0;
			bcnt_q     <= 3'd0;
			byte_cnt_q <= 8'd0;
			bad_q      <= 1'b0;
		end else if (proc) begin
			if (last_s1) begin
				chk_q      <= pcb32_pkg::CHK_INIT;
				sym_cnt_q  <= 8'd0;
				acc_q      <= 12'd0;
				bcnt_q     <= 3'd0;
				byte_cnt_q <= 8'd0;
				bad_q      <= 1'b0;
			end else begin
				chk_q      <= chk_n;
				sym_cnt_q  <= sym_cnt_n;
				acc_q      <= acc_n;
				bcnt_q     <= bcnt_n;
				byte_cnt_q <= byte_cnt_n;
				bad_q      <= bad_n;
			end
		end
	end

	// delay line, no reset: only read after eight fresh symbols
	always_ff @(posedge clk) begin
		if (proc && ms.valid) begin
			delay_q[0] <= ms.sym;
			for (int i = 1; i < pcb32_pkg::DELAY_DEPTH; i++) begin
				delay_q[i] <= delay_q[i-1];
			end
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (proc) begin
			if (push_byte) begin
				res_q[wr_ptr_q] <= '{kind: pcb32_pkg::KIND_DATA, byte_value: byte_n,
					status: pcb32_pkg::ST_OK, end_of_run: 1'b0};
			end
			if (last_s1) begin
				res_q[wr_ptr_q + PTR_W'(push_byte)] <= '{kind: pcb32_pkg::KIND_STATUS,
					byte_value: 8'd0, status: st_n, end_of_run: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = {6'b0, res_q[rd_ptr_q].status, res_q[rd_ptr_q].byte_value};
	assign m_axis_tuser  = res_q[rd_ptr_q].kind;
	assign m_axis_tlast  = res_q[rd_ptr_q].end_of_run;

	// queue never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(pcb32_pkg::RES_DEPTH))
		else $error("result queue overflow");

	// a data byte only once the delay line is full
	a_byte_full: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && push_byte) |-> (sym_cnt_q >= 8'(pcb32_pkg::DELAY_DEPTH)))
		else $error("byte emitted from partial delay line");

	// run state cleared after the final character
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && last_s1) |=> (sym_cnt_q == 8'd0 && chk_q == pcb32_pkg::CHK_INIT && !bad_q))
		else $error("run state not cleared");

	// an item that is processed always frees the input stage or is replaced
	a_s1_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && !in_acc) |=> !v_s1)
		else $error("input stage stuck");

endmodule

`default_nettype wire
